[rtl/bitmap_block_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Shared property shapes; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, defaults and status codes of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    localparam int COUNT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_ROOT  = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

[rtl/bitmap_block_allocator.sv]
// Allocate scans the bitmap one word per cycle on the single read port; a free
//   reads its word in S_DIV and clears its bit in S_FWR; refusals go to S_OUT.
// Throughput: one request in flight; the next is taken once its result is in
//   the output register, so an unread result stalls input only behind a second.
// Reset (rst_n, async low): count = 4096, then a clearing pass over the NW
//   bitmap words sets word 0 to 1, the rest 0.
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit free-block allocator over a used-bit bitmap held in block RAM.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] block_index
    input  logic [0:0]  s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] result_index
    output logic [1:0]  m_axis_tuser,   // [1:0] status

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data        // [12:0] block_count
);

    localparam int NW  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int BW  = $clog2(WORD_BITS);
    localparam int LW  = $clog2(WORD_BITS + 1);
    localparam int CW  = ($clog2(MAX_BLOCKS + 1) > bba_pkg::COUNT_W) ?
                         $clog2(MAX_BLOCKS + 1) : bba_pkg::COUNT_W;
    localparam int IW  = bba_pkg::INDEX_W;
    // index / WORD_BITS as multiply by reciprocal, exact for IW-bit indices
    localparam int DS  = IW + BW;
    localparam int DM  = (2 ** DS) / WORD_BITS + 1;
    localparam int DMW = $clog2(DM + 1);
    localparam int PW  = IW + DMW;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FWR  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [12:0]   count_reg;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0]   base_reg, base_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   q_reg, q_next;
    logic [BW-1:0]   r_reg, r_next;
    logic            mode_reg, mode_next;
    logic [IW-1:0]   res_index_reg, res_index_next;
    bba_pkg::status_t res_status_reg, res_status_next;
    logic [IW-1:0]   out_index_reg;
    bba_pkg::status_t out_status_reg;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [CW-1:0]   eff;
    logic [CW-1:0]   span;
    logic [LW-1:0]   lim;
    logic            scan_found;
    logic [BW-1:0]   scan_pos;
    logic [CW:0]     base_adv;
    logic [PW-1:0]   prod;
    logic [IW-1:0]   free_base;
    logic            in_xfer;
    logic            out_load;

    assign eff = (CW'(count_reg) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - IW){1'b0}}, out_index_reg};
    assign m_axis_tuser  = out_status_reg;

    // bits of the current word still below the effective count
    assign span     = eff - base_reg;
    assign lim      = (span >= CW'(WORD_BITS)) ? LW'(WORD_BITS) : LW'(span);
    assign base_adv = {1'b0, base_reg} + (CW + 1)'(WORD_BITS);

    assign prod      = PW'(s_axis_tdata[IW-1:0]) * PW'(DM);
    assign free_base = IW'(q_reg * IW'(WORD_BITS));

    bba_bitmap_ram #(
        .DEPTH     (NW),
        .ADDR_W    (AW),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bba_word_scan #(
        .WORD_BITS (WORD_BITS),
        .POS_W     (BW),
        .LIM_W     (LW)
    ) u_scan (
        .word  (mem_rdata),
        .lim   (lim),
        .found (scan_found),
        .pos   (scan_pos)
    );

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        base_next       = base_reg;
        idx_next        = idx_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        mode_next       = mode_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg;
        mem_wdata       = '0;
        mem_raddr       = ptr_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = (ptr_reg == '0) ? WORD_BITS'(1) : '0;
                ptr_next  = ptr_reg + AW'(1);
                if (ptr_reg == AW'(NW - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                mem_raddr = '0;
                if (in_xfer)
                begin
                    mode_next       = s_axis_tuser[0];
                    idx_next        = s_axis_tdata[IW-1:0];
                    q_next          = IW'(prod >> DS);
                    res_index_next  = '0;
                    res_status_next = bba_pkg::ST_OK;
                    base_next       = '0;
                    ptr_next        = '0;
                    if (!s_axis_tuser[0])
                    begin
                        if (eff == '0)
                        begin
                            res_status_next = bba_pkg::ST_FULL;
                            state_next      = S_OUT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (s_axis_tdata[IW-1:0] == '0)
                    begin
                        res_status_next = bba_pkg::ST_ROOT;
                        state_next      = S_OUT;
                    end
                    else if (CW'(s_axis_tdata[IW-1:0]) >= eff)
                    begin
                        res_status_next = bba_pkg::ST_RANGE;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_SCAN:
            begin
                // mem_rdata holds word ptr_reg; prefetch the next one
                mem_raddr = ptr_reg + AW'(1);
                if (scan_found)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = ptr_reg;
                    mem_wdata       = mem_rdata | (WORD_BITS'(1) << scan_pos);
                    res_index_next  = IW'(base_reg + CW'(scan_pos));
                    res_status_next = bba_pkg::ST_OK;
                    state_next      = S_OUT;
                end
                else if (base_adv >= {1'b0, eff})
                begin
                    res_index_next  = '0;
                    res_status_next = bba_pkg::ST_FULL;
                    state_next      = S_OUT;
                end
                else
                begin
                    base_next = CW'(base_adv);
                    ptr_next  = ptr_reg + AW'(1);
                end
            end
            S_DIV:
            begin
                mem_raddr  = AW'(q_reg);
                r_next     = BW'(idx_reg - free_base);
                state_next = S_FWR;
            end
            S_FWR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = AW'(q_reg);
                mem_wdata       = mem_rdata & ~(WORD_BITS'(1) << r_reg);
                res_status_next = bba_pkg::ST_OK;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            ptr_reg       <= '0;
            count_reg     <= bba_pkg::COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        idx_reg        <= idx_next;
        q_reg          <= q_next;
        r_reg          <= r_next;
        mode_reg       <= mode_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_index_reg  <= res_index_reg;
            out_status_reg <= res_status_reg;
        end
    end

`include "bitmap_block_allocator_assert.svh"

    `BBA_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_axis_tready, "second request taken while busy")
    `BBA_ASSERT_NOW(a_scan_in_range, state_reg == S_SCAN, base_reg < eff, "scan word past count")
    `BBA_ASSERT_NOW(a_full_zero, m_axis_tvalid && (m_axis_tuser == bba_pkg::ST_FULL), m_axis_tdata == '0, "full result with nonzero index")
    `BBA_ASSERT_NOW(a_free_not_full, (state_reg == S_OUT) && mode_reg, res_status_reg != bba_pkg::ST_FULL, "free answered as full")

endmodule

[rtl/bba_bitmap_ram.sv]
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// Simple dual-port bitmap store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_bitmap_ram #(
    parameter int DEPTH     = 128,
    parameter int ADDR_W    = 7,
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/bba_word_scan.sv]
// ----------------------------------------------------------------------------
// bba_word_scan
// Finds the lowest clear bit of a bitmap word among its lowest lim bits.
// ----------------------------------------------------------------------------
module bba_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int POS_W     = 5,
    parameter int LIM_W     = 6
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [LIM_W-1:0]     lim,
    output logic                 found,
    output logic [POS_W-1:0]     pos
);

    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        // walk down so the lowest candidate wins
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!word[b] && (LIM_W'(b) < lim))
            begin
                found = 1'b1;
                pos   = POS_W'(b);
            end
        end
    end

endmodule
